// ----- rtl/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the mean background subtraction block:
// action codes, register indexes, field widths and channel item payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

  // field widths
  localparam int unsigned PIX_W   = 19;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned NUM_CH  = 3;

  // register reset values
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd50;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd2228;

  // largest background level
  localparam logic [CH_W-1:0] BG_MAX = 8'hFF;

  // pixel actions; the fourth code does nothing
  typedef enum logic [1:0] {
    ACT_SET      = 2'd0,
    ACT_ACC      = 2'd1,
    ACT_CLASSIFY = 2'd2
  } action_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_SCALE     = 1'b1
  } cfg_reg_e;

  // input item
  typedef struct packed {
    logic [1:0]       action;
    logic [PIX_W-1:0] pixel_index;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [PIX_W-1:0] mask_index;
    logic             foreground;
  } out_item_t;

  // configuration write
  typedef struct packed {
    cfg_reg_e           index;
    logic [SCALE_W-1:0] value;
  } cfg_item_t;

endpackage

`default_nettype wire

// ----- rtl/mbs_stream_if.sv -----
// ----------------------------------------------------------------------------
// mbs_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbs_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/mbs_ram.sv -----
// ----------------------------------------------------------------------------
// mbs_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data; a read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_ram #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 524288,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mean_background_subtraction_core.sv -----
// ----------------------------------------------------------------------------
// mean_background_subtraction_core
// Per-pixel RGB background model: set and accumulate per-channel sums in a
// pixel-addressed RAM, classify pixels against the scaled sums.
// ----------------------------------------------------------------------------
//
//  channel    dir   payload                                   handshake
//  item_i     in    action, pixel_index, blue, green, red     valid/ready
//  result_o   out   mask_index, foreground                    valid/ready
//  cfg_i      in    index (threshold, scale), value           valid/ready
//
//  One item per cycle sustained unless the result channel stalls; a classify
//  result passes the address stage, RAM read, multiply and compare/output register.
//  The rate is set by the sum RAM: one read and one write port, one
//  read-modify-write per item, with a one-entry write forward for back-to-back
//  hits on the same pixel. Reset clears control and registers only; the RAM
//  has no clearing pass. A stalled result channel holds classify items while
//  set and accumulate items keep moving until a classify reaches the RAM stage.
//
`default_nettype none

module mean_background_subtraction_core #(
  parameter int unsigned FRAME_PIXELS = 524288,
  parameter int unsigned SUM_BITS     = 13
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mbs_stream_if.sink   item_i,
  mbs_stream_if.source result_o,
  mbs_stream_if.sink   cfg_i
);

  localparam int unsigned AddrW  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned EntryW = mbs_pkg::NUM_CH * SUM_BITS;
  localparam int unsigned ProdW  = SUM_BITS + mbs_pkg::SCALE_W;
  localparam int unsigned RecipW = mbs_pkg::PIX_W + 1;
  localparam int unsigned QprodW = mbs_pkg::PIX_W + RecipW;
  localparam int unsigned RemW   = 24;
  localparam int unsigned RprodW = mbs_pkg::PIX_W + RemW;
  localparam logic [RecipW-1:0] Recip    = RecipW'((2 ** mbs_pkg::PIX_W) / FRAME_PIXELS);
  localparam logic [RemW-1:0]   FramePix = RemW'(FRAME_PIXELS);
  localparam logic [ProdW:0]    RoundHalf = (ProdW + 1)'(2 ** (mbs_pkg::SCALE_W - 1));

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [mbs_pkg::THR_W-1:0]   threshold_q;
  logic [mbs_pkg::SCALE_W-1:0] scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= mbs_pkg::THRESHOLD_RESET;
      scale_q     <= mbs_pkg::SCALE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        mbs_pkg::CFG_THRESHOLD: threshold_q <= cfg_i.data.value[mbs_pkg::THR_W-1:0];
        mbs_pkg::CFG_SCALE:     scale_q     <= cfg_i.data.value;
        default:                threshold_q <= threshold_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic              s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  mbs_pkg::in_item_t s0_item_q, s1_item_q;
  logic              s0_adv, s0_free, s1_adv, s1_free, s2_free, out_load;
  logic              item_accept, s1_classify, ram_we;

  assign s1_classify = (s1_item_q.action == mbs_pkg::ACT_CLASSIFY);
  assign out_load    = s2_valid_q && (!out_valid_q || result_o.ready);
  assign s2_free     = !s2_valid_q || out_load;
  assign s1_adv      = s1_valid_q && (!s1_classify || s2_free);
  assign s1_free     = !s1_valid_q || s1_adv;
  assign s0_adv      = s0_valid_q && s1_free;
  assign s0_free     = !s0_valid_q || s0_adv;
  assign item_accept = item_i.valid && s0_free;
  assign item_i.ready = s0_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_valid_q <= item_i.valid;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s2_free) begin
        s2_valid_q <= s1_adv && s1_classify;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: quotient estimate of pixel_index / FRAME_PIXELS
  // --------------------------------------------------------------------------
  logic [QprodW-1:0]         quot_prod;
  logic [mbs_pkg::PIX_W-1:0] s0_quot_q;

  assign quot_prod = QprodW'(item_i.data.pixel_index) * QprodW'(Recip);

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      s0_item_q <= item_i.data;
      s0_quot_q <= quot_prod[QprodW-2:mbs_pkg::PIX_W];
    end
  end

  // remainder with one correction step gives the RAM address
  logic [RprodW-1:0] rem_prod;
  logic [RemW-1:0]   rem_raw, rem_fix;
  logic [AddrW-1:0]  s0_addr;

  always_comb begin
    rem_prod = RprodW'(s0_quot_q) * RprodW'(FramePix);
    rem_raw  = RemW'(s0_item_q.pixel_index) - rem_prod[RemW-1:0];
    rem_fix  = (rem_raw >= FramePix) ? (rem_raw - FramePix) : rem_raw;
    s0_addr  = rem_fix[AddrW-1:0];
  end

  // --------------------------------------------------------------------------
  // sum RAM
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]  s1_addr_q;
  logic [EntryW-1:0] ram_rdata, wr_data;

  mbs_ram #(
    .WIDTH (EntryW),
    .DEPTH (FRAME_PIXELS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (s0_adv),
    .raddr_i (s0_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_item_q <= s0_item_q;
      s1_addr_q <= s0_addr;
    end
  end

  // last write, forwarded over the read that raced it
  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [EntryW-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: update sums or multiply by scale
  // --------------------------------------------------------------------------
  logic [EntryW-1:0]        sums;
  logic [SUM_BITS-1:0]      sum_ch [mbs_pkg::NUM_CH];
  logic [mbs_pkg::CH_W-1:0] s1_ch  [mbs_pkg::NUM_CH];
  logic [SUM_BITS:0]        acc_ch [mbs_pkg::NUM_CH];
  logic [ProdW-1:0]         prod_ch [mbs_pkg::NUM_CH];

  assign s1_ch[0] = s1_item_q.blue;
  assign s1_ch[1] = s1_item_q.green;
  assign s1_ch[2] = s1_item_q.red;

  always_comb begin
    sums = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
    wr_data = sums;
    ram_we  = 1'b0;
    for (int c = 0; c < mbs_pkg::NUM_CH; c++) begin
      sum_ch[c]  = sums[c*SUM_BITS +: SUM_BITS];
      acc_ch[c]  = (SUM_BITS + 1)'(sum_ch[c]) + (SUM_BITS + 1)'(s1_ch[c]);
      prod_ch[c] = ProdW'(sum_ch[c]) * ProdW'(scale_q);
    end
    unique case (s1_item_q.action)
      mbs_pkg::ACT_SET: begin
        ram_we = s1_adv;
        for (int c = 0; c < mbs_pkg::NUM_CH; c++) begin
          wr_data[c*SUM_BITS +: SUM_BITS] = SUM_BITS'(s1_ch[c]);
        end
      end
      mbs_pkg::ACT_ACC: begin
        ram_we = s1_adv;
        // saturate each sum at all ones
        for (int c = 0; c < mbs_pkg::NUM_CH; c++) begin
          wr_data[c*SUM_BITS +: SUM_BITS] =
            acc_ch[c][SUM_BITS] ? {SUM_BITS{1'b1}} : acc_ch[c][SUM_BITS-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // stage 2: round, clamp and compare against threshold
  // --------------------------------------------------------------------------
  logic [mbs_pkg::PIX_W-1:0] s2_pix_q;
  logic [mbs_pkg::CH_W-1:0]  s2_ch_q   [mbs_pkg::NUM_CH];
  logic [ProdW-1:0]          s2_prod_q [mbs_pkg::NUM_CH];

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_pix_q <= s1_item_q.pixel_index;
      for (int c = 0; c < mbs_pkg::NUM_CH; c++) begin
        s2_ch_q[c]   <= s1_ch[c];
        s2_prod_q[c] <= prod_ch[c];
      end
    end
  end

  logic [ProdW:0]           rounded [mbs_pkg::NUM_CH];
  logic [SUM_BITS:0]        bg_wide [mbs_pkg::NUM_CH];
  logic [mbs_pkg::CH_W-1:0] bg      [mbs_pkg::NUM_CH];
  logic [mbs_pkg::CH_W-1:0] diff    [mbs_pkg::NUM_CH];
  logic                     fg;

  always_comb begin
    fg = 1'b0;
    for (int c = 0; c < mbs_pkg::NUM_CH; c++) begin
      rounded[c] = (ProdW + 1)'(s2_prod_q[c]) + RoundHalf;
      bg_wide[c] = rounded[c][ProdW:mbs_pkg::SCALE_W];
      bg[c]      = (bg_wide[c] > (SUM_BITS + 1)'(mbs_pkg::BG_MAX)) ?
                   mbs_pkg::BG_MAX : bg_wide[c][mbs_pkg::CH_W-1:0];
      diff[c]    = (s2_ch_q[c] > bg[c]) ? (s2_ch_q[c] - bg[c]) : (bg[c] - s2_ch_q[c]);
      if (diff[c] > threshold_q) begin
        fg = 1'b1;
      end
    end
  end

  // result register
  mbs_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.mask_index <= s2_pix_q;
      out_item_q.foreground <= fg;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a RAM write comes only from a set or accumulate item leaving stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> s1_valid_q && s1_adv &&
               (s1_item_q.action == mbs_pkg::ACT_SET ||
                s1_item_q.action == mbs_pkg::ACT_ACC))
    else $error("sum RAM written without a set or accumulate item");

  // the forward register tracks the address of the latest write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> fwd_valid_q && (fwd_addr_q == $past(s1_addr_q)))
    else $error("write forward lost the last written address");

  // a waiting classify item in stage 2 is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_load |=> s2_valid_q && $stable(s2_pix_q))
    else $error("stalled classify item dropped in stage 2");

  // an input item is taken only when stage 0 empties or is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept |-> !s0_valid_q || s0_adv)
    else $error("input item taken over a held stage 0 item");

endmodule

`default_nettype wire
